FILE: design/fjb_pkg.sv
// ----------------------------------------------------------------------------
// fjb_pkg: shared types and constants of the frame jitter buffer
// Holds the default sizes, the item mode codes, the controller state type and
// the command bundle that the controller sends to the datapath.
// ----------------------------------------------------------------------------
package fjb_pkg;

    localparam int QUEUE_DEPTH_DEF = 8;
    localparam int FRAME_BYTES_DEF = 256;

    localparam int BYTE_W  = 8;
    localparam int CFG_W   = 4;
    localparam int COUNT_W = 4;

    localparam logic [CFG_W-1:0] START_FRAMES_RST = 4'd3;

    // Item modes; the fourth code is unused and only runs the start check.
    typedef enum logic [1:0] {
        MODE_PUSH  = 2'd0,
        MODE_POP   = 2'd1,
        MODE_FLUSH = 2'd2
    } t_mode;

    typedef enum logic [0:0] {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    typedef struct packed {
        logic accept;   // capture the input word and start the memory reads
        logic execute;  // apply the item and load the result register
    } t_ctl_cmd;

endpackage

FILE: design/fjb_ram.sv
// ----------------------------------------------------------------------------
// fjb_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module fjb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/fjb_ctrl.sv
// ----------------------------------------------------------------------------
// fjb_ctrl: sequencing of the frame jitter buffer
// Two-state machine that accepts a word, lets the memory reads settle and then
// applies the item once the result register is free.
// ----------------------------------------------------------------------------
module fjb_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output fjb_pkg::t_ctl_cmd o_cmd
);

    import fjb_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready     = 1'b0;
        o_cmd.accept   = 1'b0;
        o_cmd.execute  = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            S_EXEC: begin
                o_cmd.execute = out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.execute) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    // An accepted word is always followed by its execute step.
    a_accept_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |=> r_state == S_EXEC)
        else $error("accepted word did not move the controller to execute");

    // A blocked result register holds the controller in execute.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EXEC && r_out_valid && !i_out_ready |=> r_state == S_EXEC)
        else $error("item executed while the result register was still full");

endmodule

FILE: design/fjb_datapath.sv
// ----------------------------------------------------------------------------
// fjb_datapath: frame ring state, frame memories and result register
// Keeps ring pointers and offsets, drives both RAMs and applies one item per
// execute command.
// ----------------------------------------------------------------------------
module fjb_datapath #(
    parameter int QUEUE_DEPTH = fjb_pkg::QUEUE_DEPTH_DEF,
    parameter int FRAME_BYTES = fjb_pkg::FRAME_BYTES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  fjb_pkg::t_ctl_cmd             i_cmd,
    input  logic                          i_cfg_valid,
    input  logic [fjb_pkg::CFG_W-1:0]     i_cfg_start_frames,
    input  logic [1:0]                    i_mode,
    input  logic [fjb_pkg::BYTE_W-1:0]    i_push_byte,
    input  logic                          i_byte_present,
    input  logic                          i_frame_end,
    output logic [fjb_pkg::BYTE_W-1:0]    o_pop_byte,
    output logic                          o_pop_last,
    output logic                          o_status,
    output logic [fjb_pkg::COUNT_W-1:0]   o_frames_held,
    output logic                          o_started,
    output logic                          o_dropped_oldest
);

    import fjb_pkg::*;

    localparam int SLOT_W      = $clog2(QUEUE_DEPTH);
    localparam int OFS_W       = $clog2(FRAME_BYTES);
    localparam int LEN_W       = $clog2(FRAME_BYTES + 1);
    localparam int HC_W        = $clog2(QUEUE_DEPTH + 1);
    localparam int CMP_W       = (HC_W > CFG_W) ? HC_W : CFG_W;
    localparam int STORE_DEPTH = QUEUE_DEPTH << OFS_W;

    // Ring state.
    logic [SLOT_W-1:0] r_head, n_head;
    logic [SLOT_W-1:0] r_tail, n_tail;
    logic [HC_W-1:0]   r_held, n_held;
    logic              r_started, n_started;
    logic [LEN_W-1:0]  r_wofs, n_wofs;
    logic [LEN_W-1:0]  r_rofs, n_rofs;
    logic              r_active, n_active;
    logic [CFG_W-1:0]  r_start_frames;

    // Captured input word.
    logic [1:0]        r_mode;
    logic [BYTE_W-1:0] r_byte;
    logic              r_present;
    logic              r_fend;

    // Result register.
    logic [BYTE_W-1:0]  r_pop_byte, n_pop_byte;
    logic               r_pop_last, n_pop_last;
    logic               r_status, n_status;
    logic               r_dropped, n_dropped;

    // Memory ports.
    logic                          store_we;
    logic [SLOT_W+OFS_W-1:0]       store_waddr;
    logic [SLOT_W+OFS_W-1:0]       store_raddr;
    logic [BYTE_W-1:0]             store_rdata;
    logic                          len_we;
    logic [LEN_W-1:0]              len_wdata;
    logic [LEN_W-1:0]              len_rdata;

    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
        next_slot = (s == SLOT_W'(QUEUE_DEPTH - 1)) ? '0 : s + 1'b1;
    endfunction

    // Reads always address the head frame at the current read position.
    assign store_raddr = {r_head, r_rofs[OFS_W-1:0]};

    fjb_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (store_we),
        .i_waddr (store_waddr),
        .i_wdata (r_byte),
        .i_raddr (store_raddr),
        .o_rdata (store_rdata)
    );

    fjb_ram #(
        .WIDTH (LEN_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_lengths (
        .i_clk   (i_clk),
        .i_we    (len_we),
        .i_waddr (r_tail),
        .i_wdata (len_wdata),
        .i_raddr (r_head),
        .o_rdata (len_rdata)
    );

    always_comb begin
        n_head      = r_head;
        n_tail      = r_tail;
        n_held      = r_held;
        n_started   = r_started;
        n_wofs      = r_wofs;
        n_rofs      = r_rofs;
        n_active    = r_active;
        n_pop_byte  = '0;
        n_pop_last  = 1'b0;
        n_status    = 1'b0;
        n_dropped   = 1'b0;
        store_we    = 1'b0;
        store_waddr = {r_tail, r_wofs[OFS_W-1:0]};
        len_we      = 1'b0;
        len_wdata   = r_wofs;

        case (r_mode)
            MODE_PUSH: begin
                if (!r_active) begin
                    // A new frame into a full ring pushes out the oldest one.
                    if (r_held >= HC_W'(QUEUE_DEPTH)) begin
                        n_head    = next_slot(r_head);
                        n_held    = r_held - 1'b1;
                        n_rofs    = '0;
                        n_dropped = 1'b1;
                    end
                    n_wofs = '0;
                end
                store_waddr = {r_tail, n_wofs[OFS_W-1:0]};
                if (r_present && n_wofs < LEN_W'(FRAME_BYTES)) begin
                    store_we = 1'b1;
                    n_wofs   = n_wofs + 1'b1;
                end
                if (r_fend) begin
                    len_we    = 1'b1;
                    len_wdata = n_wofs;
                    n_tail    = next_slot(r_tail);
                    n_held    = n_held + 1'b1;
                    n_wofs    = '0;
                    n_active  = 1'b0;
                end else begin
                    n_active = 1'b1;
                end
            end
            MODE_POP: begin
                if (r_held == '0) begin
                    n_status = 1'b1;
                end else begin
                    if (r_rofs < len_rdata) begin
                        n_pop_byte = store_rdata;
                        n_rofs     = r_rofs + 1'b1;
                    end
                    if (n_rofs >= len_rdata) begin
                        n_pop_last = 1'b1;
                        n_head     = next_slot(r_head);
                        n_held     = r_held - 1'b1;
                        n_rofs     = '0;
                    end
                end
            end
            MODE_FLUSH: begin
                n_head    = '0;
                n_tail    = '0;
                n_held    = '0;
                n_started = 1'b0;
                n_wofs    = '0;
                n_rofs    = '0;
                n_active  = 1'b0;
            end
            default: begin
                n_head = r_head;
            end
        endcase

        if (r_mode != MODE_FLUSH && !r_started
            && CMP_W'(n_held) >= CMP_W'(r_start_frames)) begin
            n_started = 1'b1;
        end

        if (!i_cmd.execute) begin
            store_we = 1'b0;
            len_we   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head         <= '0;
            r_tail         <= '0;
            r_held         <= '0;
            r_started      <= 1'b0;
            r_wofs         <= '0;
            r_rofs         <= '0;
            r_active       <= 1'b0;
            r_start_frames <= START_FRAMES_RST;
        end else begin
            if (i_cfg_valid) begin
                r_start_frames <= i_cfg_start_frames;
            end
            if (i_cmd.execute) begin
                r_head    <= n_head;
                r_tail    <= n_tail;
                r_held    <= n_held;
                r_started <= n_started;
                r_wofs    <= n_wofs;
                r_rofs    <= n_rofs;
                r_active  <= n_active;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_mode    <= i_mode;
            r_byte    <= i_push_byte;
            r_present <= i_byte_present;
            r_fend    <= i_frame_end;
        end
        if (i_cmd.execute) begin
            r_pop_byte <= n_pop_byte;
            r_pop_last <= n_pop_last;
            r_status   <= n_status;
            r_dropped  <= n_dropped;
        end
    end

    // The reported count and flag are always the live state after the item.
    assign o_pop_byte       = r_pop_byte;
    assign o_pop_last       = r_pop_last;
    assign o_status         = r_status;
    assign o_frames_held    = COUNT_W'(r_held);
    assign o_started        = r_started;
    assign o_dropped_oldest = r_dropped;

    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= HC_W'(QUEUE_DEPTH))
        else $error("held frame count exceeds the ring depth");

    a_flush_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.execute && r_mode == MODE_FLUSH |=> !r_started && r_held == '0)
        else $error("flush left frames or the started flag behind");

    a_state_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.execute |=> $stable(r_held) && $stable(r_head) && $stable(r_tail))
        else $error("ring pointers moved without an execute step");

    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.execute && n_dropped |-> r_held == HC_W'(QUEUE_DEPTH))
        else $error("oldest frame dropped while the ring was not full");

endmodule

FILE: design/frame_jitter_buffer_top.sv
// ----------------------------------------------------------------------------
// frame_jitter_buffer_top: ring buffer of variable-length audio frames
// Frames are pushed and popped one byte per word; a full ring drops its oldest
// frame when a new one starts, and a latched started flag marks playback.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (i_in_valid / o_in_ready) carries one word per item: a
// push byte, a pop request or a flush. The output channel (o_out_valid /
// i_out_ready) returns exactly one result word per input word, in order.
// The configuration channel (i_cfg_valid / o_cfg_ready) writes start_frames;
// it is always ready and should only be used while no item is in flight.
// A word is accepted in the idle cycle; the frame and length memories are read
// on that edge, and the item is applied and its result registered in the
// execute step once the output register is free. The registered read of the
// frame memory thus sits ahead of the update, and a new word is taken only
// after the current item has been applied. The next word can be accepted
// while a result still waits in the output register. If the receiver stalls,
// the block holds its next item in the execute cycle until the output register
// frees up.
// Reset empties the ring, clears the started flag and sets start_frames to 3.
// Memory contents are not cleared: only bytes and lengths written for a
// committed frame are ever read back, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module frame_jitter_buffer_top #(
    parameter int QUEUE_DEPTH = fjb_pkg::QUEUE_DEPTH_DEF,
    parameter int FRAME_BYTES = fjb_pkg::FRAME_BYTES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Configuration write channel.
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [fjb_pkg::CFG_W-1:0]     i_cfg_start_frames,
    // Input channel.
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [1:0]                    i_mode,
    input  logic [fjb_pkg::BYTE_W-1:0]    i_push_byte,
    input  logic                          i_byte_present,
    input  logic                          i_frame_end,
    // Output channel.
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [fjb_pkg::BYTE_W-1:0]    o_pop_byte,
    output logic                          o_pop_last,
    output logic                          o_status,
    output logic [fjb_pkg::COUNT_W-1:0]   o_frames_held,
    output logic                          o_started,
    output logic                          o_dropped_oldest
);

    import fjb_pkg::*;

    t_ctl_cmd cmd;

    // The start threshold register takes a write on any cycle.
    assign o_cfg_ready = 1'b1;

    fjb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    fjb_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .FRAME_BYTES (FRAME_BYTES)
    ) u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .i_cfg_valid        (i_cfg_valid),
        .i_cfg_start_frames (i_cfg_start_frames),
        .i_mode             (i_mode),
        .i_push_byte        (i_push_byte),
        .i_byte_present     (i_byte_present),
        .i_frame_end        (i_frame_end),
        .o_pop_byte         (o_pop_byte),
        .o_pop_last         (o_pop_last),
        .o_status           (o_status),
        .o_frames_held      (o_frames_held),
        .o_started          (o_started),
        .o_dropped_oldest   (o_dropped_oldest)
    );

endmodule

FILE: test/frame_jitter_buffer_top_tb.sv
// ----------------------------------------------------------------------------
// frame_jitter_buffer_top_tb: self-checking bench for the frame jitter buffer
// Drives push, pop, flush and unused-mode words through the valid/ready input
// channel and checks every result word against a behavioral model of the ring.
// Runs a directed opening, then random frame traffic over several start
// thresholds and idling patterns, including a long receiver hold-off.
// ----------------------------------------------------------------------------

typedef struct packed {
    logic [1:0] mode;
    logic [7:0] data;
    logic       present;
    logic       fend;
} ring_item_t;

typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       status;
    logic [3:0] held;
    logic       started;
    logic       dropped;
} ring_result_t;

// Model of the frame ring plus the queue of result words still owed by the block.
class frame_ring_scoreboard;
    logic [7:0]   frame_bytes [fjb_pkg::QUEUE_DEPTH_DEF][fjb_pkg::FRAME_BYTES_DEF];
    int unsigned  frame_len [fjb_pkg::QUEUE_DEPTH_DEF];
    int unsigned  head;
    int unsigned  tail;
    int unsigned  held;
    int unsigned  wr_off;
    int unsigned  rd_off;
    bit           pushing;
    bit           started;
    logic [3:0]   start_frames;
    ring_result_t pending_results [$];
    int unsigned  words_checked;
    int unsigned  mismatches;

    function new();
        start_frames  = fjb_pkg::START_FRAMES_RST;
        words_checked = 0;
        mismatches    = 0;
        empty_ring();
    endfunction

    function void empty_ring();
        head    = 0;
        tail    = 0;
        held    = 0;
        wr_off  = 0;
        rd_off  = 0;
        pushing = 1'b0;
        started = 1'b0;
    endfunction

    function int unsigned ring_next(int unsigned slot);
        return (slot + 1 >= fjb_pkg::QUEUE_DEPTH_DEF) ? 0 : slot + 1;
    endfunction

    // Applies one accepted word to the ring and queues the result it must give.
    function void predict_word(ring_item_t w);
        ring_result_t r;
        r = '0;
        case (w.mode)
            fjb_pkg::MODE_PUSH: begin
                if (!pushing) begin
                    // A new frame into a full ring pushes out the oldest one.
                    if (held >= fjb_pkg::QUEUE_DEPTH_DEF) begin
                        head      = ring_next(head);
                        held--;
                        rd_off    = 0;
                        r.dropped = 1'b1;
                    end
                    wr_off = 0;
                end
                if (w.present && wr_off < fjb_pkg::FRAME_BYTES_DEF) begin
                    frame_bytes[tail][wr_off] = w.data;
                    wr_off++;
                end
                if (w.fend) begin
                    frame_len[tail] = wr_off;
                    tail    = ring_next(tail);
                    held++;
                    wr_off  = 0;
                    pushing = 1'b0;
                end else begin
                    pushing = 1'b1;
                end
            end
            fjb_pkg::MODE_POP: begin
                if (held == 0) begin
                    r.status = 1'b1;
                end else begin
                    if (rd_off < frame_len[head]) begin
                        r.data = frame_bytes[head][rd_off];
                        rd_off++;
                    end
                    if (rd_off >= frame_len[head]) begin
                        r.last = 1'b1;
                        head   = ring_next(head);
                        held--;
                        rd_off = 0;
                    end
                end
            end
            fjb_pkg::MODE_FLUSH: begin
                empty_ring();
            end
            default: begin
            end
        endcase
        if (w.mode != fjb_pkg::MODE_FLUSH && !started && held >= start_frames)
            started = 1'b1;
        r.held    = 4'(held);
        r.started = started;
        pending_results.push_back(r);
    endfunction

    task report(string what);
        mismatches++;
        if (mismatches <= 50)
            $display("MISMATCH at %0t: %s", $time, what);
    endtask

    function string show(ring_result_t r);
        return $sformatf("{byte %02h last %0d status %0d held %0d started %0d dropped %0d}",
                         r.data, r.last, r.status, r.held, r.started, r.dropped);
    endfunction

    task check_word(ring_result_t got);
        ring_result_t want;
        string        bad;
        words_checked++;
        if (pending_results.size() == 0) begin
            report($sformatf("result word %0d %s with nothing expected",
                             words_checked, show(got)));
        end else begin
            want = pending_results.pop_front();
            bad  = "";
            if (got.data    !== want.data)    bad = {bad, " pop_byte"};
            if (got.last    !== want.last)    bad = {bad, " pop_last"};
            if (got.status  !== want.status)  bad = {bad, " status"};
            if (got.held    !== want.held)    bad = {bad, " frames_held"};
            if (got.started !== want.started) bad = {bad, " started"};
            if (got.dropped !== want.dropped) bad = {bad, " dropped_oldest"};
            if (bad != "")
                report($sformatf("result word %0d:%s differ, got %s expected %s",
                                 words_checked, bad, show(got), show(want)));
        end
    endtask
endclass

module frame_jitter_buffer_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         QUEUE_DEPTH     = fjb_pkg::QUEUE_DEPTH_DEF;
    localparam int         FRAME_BYTES     = fjb_pkg::FRAME_BYTES_DEF;
    localparam int         HALF_PERIOD     = 5;
    localparam int         RESET_CYCLES    = 5;
    // The fourth mode code has no name in the package; the block only runs its
    // started check for it.
    localparam logic [1:0] MODE_UNUSED     = 2'd3;
    localparam int         ITEMS_PER_PHASE = 110;
    localparam int         HOLD_OFF_CYCLES = 300;
    // Longest legal quiet stretch is the receiver hold-off; allow ten times that.
    localparam int         QUIET_LIMIT     = 3000;
    localparam int         PHASES          = 5;

    // Per-phase settings: start threshold, sender idle and receiver stall rates
    // in percent. The last phase draws its threshold at random.
    localparam int START_SEQ  [PHASES] = '{0, 8, 15, 1, 0};
    localparam int SEND_IDLE  [PHASES] = '{0, 75, 0, 16, 0};
    localparam int RECV_STALL [PHASES] = '{0, 0, 75, 16, 0};

    logic                          i_clk              = 1'b0;
    logic                          i_rst_n            = 1'b0;
    logic                          i_cfg_valid        = 1'b0;
    logic                          o_cfg_ready;
    logic [fjb_pkg::CFG_W-1:0]     i_cfg_start_frames = '0;
    logic                          i_in_valid         = 1'b0;
    logic                          o_in_ready;
    logic [1:0]                    i_mode             = '0;
    logic [fjb_pkg::BYTE_W-1:0]    i_push_byte        = '0;
    logic                          i_byte_present     = 1'b0;
    logic                          i_frame_end        = 1'b0;
    logic                          o_out_valid;
    logic                          i_out_ready        = 1'b0;
    logic [fjb_pkg::BYTE_W-1:0]    o_pop_byte;
    logic                          o_pop_last;
    logic                          o_status;
    logic [fjb_pkg::COUNT_W-1:0]   o_frames_held;
    logic                          o_started;
    logic                          o_dropped_oldest;

    frame_ring_scoreboard board = new();

    // Idle rates of the two sides, changed by the main sequence between phases.
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    // The main sequence asks for a hold-off by bumping hold_requests; the
    // receiver process serves it and counts the cycles itself.
    int unsigned hold_requests  = 0;
    int unsigned holds_served   = 0;
    int unsigned hold_left      = 0;
    int unsigned items_sent     = 0;
    int unsigned quiet_cycles   = 0;

    frame_jitter_buffer_top #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .FRAME_BYTES (FRAME_BYTES)
    ) u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_start_frames (i_cfg_start_frames),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_mode             (i_mode),
        .i_push_byte        (i_push_byte),
        .i_byte_present     (i_byte_present),
        .i_frame_end        (i_frame_end),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_pop_byte         (o_pop_byte),
        .o_pop_last         (o_pop_last),
        .o_status           (o_status),
        .o_frames_held      (o_frames_held),
        .o_started          (o_started),
        .o_dropped_oldest   (o_dropped_oldest)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // Both channels are observed at the rising edge. The input word is noted
    // first, so a result that left in the same edge would still find it.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready)
                board.predict_word(ring_item_t'{i_mode, i_push_byte,
                                                i_byte_present, i_frame_end});
            if (o_out_valid && i_out_ready)
                board.check_word(ring_result_t'{o_pop_byte, o_pop_last, o_status,
                                                o_frames_held, o_started,
                                                o_dropped_oldest});
        end
    end

    // Watchdog: any handshake on any channel counts as progress.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Receiver: random stalls at the phase rate, or a long hold-off on request.
    always @(negedge i_clk) begin
        if (hold_requests != holds_served) begin
            holds_served = hold_requests;
            hold_left    = HOLD_OFF_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Offers one word and returns at the falling edge after it was accepted.
    // Valid is left high there, so back-to-back words keep it up without a dip.
    task automatic send_word(input logic [1:0] mode, input logic [7:0] data,
                             input logic present, input logic fend);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_mode         <= mode;
        i_push_byte    <= data;
        i_byte_present <= present;
        i_frame_end    <= fend;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        items_sent++;
        @(negedge i_clk);
    endtask

    // Drops valid and waits until every result word owed has been taken.
    // Always waits for a falling edge first, so valid is not raised in the same step.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (board.pending_results.size() != 0);
    endtask

    task automatic write_start_frames(input logic [3:0] value);
        i_cfg_valid        <= 1'b1;
        i_cfg_start_frames <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        board.start_frames = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Pushes a frame of len data bytes. The end mark either rides on the last
    // byte or comes as a word of its own without data; an empty frame always
    // takes the latter. Now and then a data-less word sits inside the frame.
    task automatic push_frame(input int unsigned len);
        bit end_alone;
        end_alone = (len == 0) || ($urandom_range(1) == 1);
        for (int unsigned i = 0; i < len; i++) begin
            if ($urandom_range(15) == 0)
                send_word(fjb_pkg::MODE_PUSH, 8'($urandom_range(255)), 1'b0, 1'b0);
            send_word(fjb_pkg::MODE_PUSH, 8'($urandom_range(255)), 1'b1,
                      !end_alone && (i == len - 1));
        end
        if (end_alone)
            send_word(fjb_pkg::MODE_PUSH, 8'($urandom_range(255)), 1'b0, 1'b1);
    endtask

    task automatic pop_run(input int unsigned count);
        repeat (count)
            send_word(fjb_pkg::MODE_POP, 8'($urandom_range(255)),
                      1'($urandom_range(1)), 1'($urandom_range(1)));
    endtask

    // Random traffic: mostly whole frames and pop runs, weighted toward pushes
    // so the ring fills and starts dropping, plus frames broken up by pops or
    // abandoned by a flush, lone flushes and plain noise words.
    task automatic run_traffic(input int unsigned count);
        int unsigned stop;
        int unsigned pick;
        stop = items_sent + count;
        while (items_sent < stop) begin
            pick = $urandom_range(99);
            if (pick < 50) begin
                push_frame($urandom_range(8));
            end else if (pick < 72) begin
                pop_run($urandom_range(1, 10));
            end else if (pick < 84) begin
                send_word(fjb_pkg::MODE_PUSH, 8'($urandom_range(255)), 1'b1, 1'b0);
                pop_run($urandom_range(1, 4));
                if ($urandom_range(3) == 0)
                    send_word(fjb_pkg::MODE_FLUSH, 8'($urandom_range(255)),
                              1'($urandom_range(1)), 1'($urandom_range(1)));
                else
                    push_frame($urandom_range(4));
            end else if (pick < 87) begin
                send_word(fjb_pkg::MODE_FLUSH, 8'($urandom_range(255)),
                          1'($urandom_range(1)), 1'($urandom_range(1)));
            end else begin
                repeat ($urandom_range(1, 4))
                    send_word(2'($urandom_range(3)), 8'($urandom_range(255)),
                              1'($urandom_range(1)), 1'($urandom_range(1)));
            end
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed opening with the reset threshold of three frames.
        // Pop from an empty ring, then a word with the unused mode code.
        send_word(fjb_pkg::MODE_POP, 8'h00, 1'b0, 1'b0);
        send_word(MODE_UNUSED, 8'hA5, 1'b1, 1'b1);
        // A two-byte frame at both byte extremes, closed by a data-less end mark.
        send_word(fjb_pkg::MODE_PUSH, 8'h00, 1'b1, 1'b0);
        send_word(fjb_pkg::MODE_PUSH, 8'hFF, 1'b1, 1'b0);
        send_word(fjb_pkg::MODE_PUSH, 8'h00, 1'b0, 1'b1);
        // An empty frame; its pop returns a zero byte flagged as last.
        send_word(fjb_pkg::MODE_PUSH, 8'h5A, 1'b0, 1'b1);
        pop_run(3);
        // The ring is empty again.
        send_word(fjb_pkg::MODE_POP, 8'hFF, 1'b1, 1'b1);
        // Fill all slots: one two-byte frame, then single-byte frames. The
        // started flag latches on the way.
        send_word(fjb_pkg::MODE_PUSH, 8'h11, 1'b1, 1'b0);
        send_word(fjb_pkg::MODE_PUSH, 8'h22, 1'b1, 1'b1);
        for (int i = 0; i < QUEUE_DEPTH - 1; i++)
            send_word(fjb_pkg::MODE_PUSH, 8'(8'h80 + i), 1'b1, 1'b1);
        // Read half of the oldest frame, then start a new frame into the full
        // ring: the half-read frame is dropped and reading restarts at the
        // next frame's first byte.
        send_word(fjb_pkg::MODE_POP, 8'h00, 1'b0, 1'b0);
        send_word(fjb_pkg::MODE_PUSH, 8'h33, 1'b1, 1'b1);
        send_word(fjb_pkg::MODE_POP, 8'h00, 1'b0, 1'b0);
        // Flush with a frame still open; afterwards nothing is left to pop.
        send_word(fjb_pkg::MODE_PUSH, 8'h44, 1'b1, 1'b0);
        send_word(fjb_pkg::MODE_FLUSH, 8'h00, 1'b0, 1'b0);
        send_word(fjb_pkg::MODE_POP, 8'h00, 1'b0, 1'b0);

        for (int phase = 0; phase < PHASES; phase++) begin
            // The threshold is only rewritten with nothing in flight.
            wait_drained();
            send_idle_pct  = SEND_IDLE[phase];
            recv_stall_pct = RECV_STALL[phase];
            write_start_frames(phase < PHASES - 1 ? 4'(START_SEQ[phase])
                                                  : 4'($urandom_range(15)));
            // Start each phase from an empty ring so the new threshold shows.
            send_word(fjb_pkg::MODE_FLUSH, 8'($urandom_range(255)), 1'b1, 1'b1);
            if (phase == PHASES - 1) begin
                // A frame longer than a slot: the bytes past the limit are lost.
                push_frame($urandom_range(FRAME_BYTES + 1, FRAME_BYTES + 6));
                run_traffic(40);
                // Long receiver hold-off while words keep coming, so the block
                // backs up and stops taking input.
                hold_requests++;
                run_traffic(60);
                // Sender waits until the block has answered everything.
                wait_drained();
                run_traffic(60);
            end else begin
                run_traffic(ITEMS_PER_PHASE);
            end
        end

        wait_drained();
        // Waiting on after the drain catches any stray result word after the last one.
        repeat (10) @(negedge i_clk);
        if (board.mismatches == 0 && board.pending_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
